// ===== src/hki_pkg.sv =====
// shared types and constants for the hermite keyframe interpolator
// no dependencies
`default_nettype none
package hki_pkg;

   localparam int MAX_KEYS = 64;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);
   localparam int FRAME_W  = 20;
   localparam int DATA_W   = 32;
   localparam int T_W      = 30;
   localparam int HELD_W   = 7;

   // op codes
   localparam logic [1:0] OP_QUERY = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_ORDER = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // one stored key
   typedef struct packed {
      logic [FRAME_W-1:0]       frame;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] slope;
   } key_type;

endpackage
`default_nettype wire

// ===== src/hki_div.sv =====
// serial restoring divider: quotient = floor(num * 2^30 / den), num < den
// uses hki_pkg
`default_nettype none
module hki_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [hki_pkg::FRAME_W-1:0]  num,
   input  wire logic [hki_pkg::FRAME_W-1:0]  den,
   output logic                              done,
   output logic [hki_pkg::T_W-1:0]           quot
);

   localparam int STEP_W = $clog2(hki_pkg::T_W + 1);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [hki_pkg::FRAME_W-1:0]   rem_ff, rem_in;
   logic [hki_pkg::FRAME_W-1:0]   den_ff, den_in;
   logic [hki_pkg::T_W-1:0]       quo_ff, quo_in;
   logic [hki_pkg::FRAME_W:0]     rem2;

   // one quotient bit per cycle
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem2    = {rem_ff, 1'b0};
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = num;
         den_in  = den;
         quo_in  = '0;
      end else if (run_ff) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_in = hki_pkg::FRAME_W'(rem2 - {1'b0, den_ff});
            quo_in = {quo_ff[hki_pkg::T_W-2:0], 1'b1};
         end else begin
            rem_in = hki_pkg::FRAME_W'(rem2);
            quo_in = {quo_ff[hki_pkg::T_W-2:0], 1'b0};
         end
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(hki_pkg::T_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule
`default_nettype wire

// ===== src/hermite_keyframe_interpolator_unit.sv =====
// top level of the hermite keyframe interpolator: key memory, search, blend
// uses hki_pkg and hki_div
//
//   channel   ports                         handshake
//   request   req_op/frame/key_value/slope  taken when start high and busy low
//   response  rsp_value/status/keys_held    one cycle, marked by rsp_strobe
//
// load, clear, unused op and empty query: result in the cycle after the beat.
// query: result after up to seven probes of the binary search over the single read
// port of the key memory, closing the search and fetching both keys, the 30-step
// serial divide, and eight passes through the shared multiplier.
// synchronous reset empties the table; memory contents need no clearing.
// the receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module hermite_keyframe_interpolator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_op,
   input  wire logic [hki_pkg::FRAME_W-1:0]         req_frame,
   input  wire logic signed [hki_pkg::DATA_W-1:0]   req_key_value,
   input  wire logic signed [hki_pkg::DATA_W-1:0]   req_key_slope,
   output logic                                     rsp_strobe,
   output logic signed [hki_pkg::DATA_W-1:0]        rsp_value,
   output logic [1:0]                               rsp_status,
   output logic [hki_pkg::HELD_W-1:0]               rsp_keys_held
);

   localparam int IW = hki_pkg::IDX_W;
   localparam int CW = hki_pkg::CNT_W;
   localparam int FW = hki_pkg::FRAME_W;
   localparam int DW = hki_pkg::DATA_W;
   localparam int TW = hki_pkg::T_W;
   localparam int AW = 54;
   localparam int MA = 44;
   localparam int PW = MA + DW;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_NX   = 3'd3;
   localparam logic [2:0] S_PV   = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_MUL  = 3'd6;
   localparam logic [2:0] S_ACC  = 3'd7;

   // key memory, one write and one registered read port
   hki_pkg::key_type key_mem [hki_pkg::MAX_KEYS];
   hki_pkg::key_type rd_ff;
   logic [IW-1:0]    rd_addr;
   logic             wr_en;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [FW-1:0] last_ff, last_in;
   logic [FW-1:0] q_ff, q_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] mid;
   logic [IW-1:0] nx_ff, nx_in;
   logic [IW-1:0] nx_sel;
   hki_pkg::key_type kn_ff, kn_in, kp_ff, kp_in;
   logic [FW-1:0] nf_ff, nf_in, d_ff, d_in;
   logic          div_go_ff;
   logic          div_done;
   logic [TW-1:0] div_q;
   logic [TW-1:0] t_ff, t_in, t2_ff, t2_in, t3_ff, t3_in;
   logic signed [DW-1:0] h00_ff, h00_in, h01_ff, h01_in, h10_ff, h10_in, h11_ff, h11_in;
   logic signed [33:0] t2s, t3s, ts;
   logic [2:0]    step_ff, step_in;
   logic signed [MA-1:0] mul_a;
   logic signed [DW-1:0] mul_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [MA-1:0] tmp_ff, tmp_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic signed [DW-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   hki_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (d_ff),
      .den   (nf_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   assign mid    = CW'((lo_ff + hi_ff) >> 1);
   assign nx_sel = (lo_ff >= cnt_ff) ? IW'(cnt_ff - 1'b1) : IW'(lo_ff);
   assign t2s    = {4'b0, t2_ff};
   assign t3s    = {4'b0, prod_ff[2*TW-1:TW]};
   assign ts     = {4'b0, t_ff};

   // shared multiplier operand select
   always_comb begin
      case (step_ff)
         3'd0: begin mul_a = MA'($signed({1'b0, t_ff}));  mul_b = DW'($signed({1'b0, t_ff})); end
         3'd1: begin mul_a = MA'($signed({1'b0, t2_ff})); mul_b = DW'($signed({1'b0, t_ff})); end
         3'd2: begin mul_a = MA'(kp_ff.value); mul_b = h00_ff; end
         3'd3: begin mul_a = MA'(kn_ff.value); mul_b = h01_ff; end
         3'd4: begin mul_a = MA'(kp_ff.slope); mul_b = h10_ff; end
         3'd6: begin mul_a = MA'(kn_ff.slope); mul_b = h11_ff; end
         default: begin mul_a = tmp_ff; mul_b = DW'($signed({1'b0, nf_ff})); end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      q_in          = q_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      nx_in         = nx_ff;
      kn_in         = kn_ff;
      kp_in         = kp_ff;
      nf_in         = nf_ff;
      d_in          = d_ff;
      t_in          = t_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      h00_in        = h00_ff;
      h01_in        = h01_ff;
      h10_in        = h10_ff;
      h11_in        = h11_ff;
      step_in       = step_ff;
      tmp_in        = tmp_ff;
      acc_in        = acc_ff;
      rd_addr       = IW'(mid);
      wr_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = hki_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               q_in = req_frame;
               case (req_op)
                  hki_pkg::OP_QUERY: begin
                     if (cnt_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = hki_pkg::ST_EMPTY;
                     end else begin
                        lo_in    = '0;
                        hi_in    = cnt_ff;
                        state_in = S_SRCH;
                     end
                  end
                  hki_pkg::OP_LOAD: begin
                     rsp_strobe_in = 1'b1;
                     if (cnt_ff != '0 && req_frame <= last_ff) begin
                        rsp_status_in = hki_pkg::ST_ORDER;
                     end else if (cnt_ff >= CW'(hki_pkg::MAX_KEYS)) begin
                        rsp_status_in = hki_pkg::ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        last_in = req_frame;
                        cnt_in  = CW'(cnt_ff + 1'b1);
                     end
                  end
                  hki_pkg::OP_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     cnt_in        = '0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         // lower bound search, each probe reads in S_SRCH and compares in S_CMP
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               state_in = S_CMP;
            end else begin
               rd_addr  = nx_sel;
               nx_in    = nx_sel;
               state_in = S_NX;
            end
         end
         S_CMP: begin
            if (rd_ff.frame < q_ff) lo_in = CW'(mid + 1'b1);
            else hi_in = mid;
            state_in = S_SRCH;
         end
         // next key captured; fetch previous key if a blend is due
         S_NX: begin
            kn_in   = rd_ff;
            rd_addr = IW'(nx_ff - 1'b1);
            if (q_ff < rd_ff.frame && nx_ff != '0) begin
               state_in = S_PV;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = rd_ff.value;
               state_in      = S_IDLE;
            end
         end
         S_PV: begin
            kp_in    = rd_ff;
            nf_in    = FW'(kn_ff.frame - rd_ff.frame);
            d_in     = FW'(q_ff - rd_ff.frame);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               t_in     = div_q;
               step_in  = '0;
               acc_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         // consume the product of this step
         S_ACC: begin
            state_in = S_MUL;
            step_in  = 3'(step_ff + 1'b1);
            case (step_ff)
               3'd0: t2_in = prod_ff[2*TW-1:TW];
               3'd1: begin
                  t3_in  = prod_ff[2*TW-1:TW];
                  h00_in = DW'(34'sd1073741824 - 3 * t2s + 2 * t3s);
                  h01_in = DW'(3 * t2s - 2 * t3s);
                  h10_in = DW'(ts - 2 * t2s + t3s);
                  h11_in = DW'(t3s - t2s);
               end
               3'd2, 3'd3: acc_in = AW'(acc_ff + AW'(prod_ff >>> 30));
               3'd4, 3'd6: tmp_in = MA'(prod_ff >>> 20);
               default: begin
                  acc_in = AW'(acc_ff + AW'(prod_ff >>> 14));
                  if (step_ff == 3'd7) begin
                     state_in = S_IDLE;
                     rsp_strobe_in = 1'b1;
                     if (acc_in > AW'(64'sh7FFFFFFF))
                        rsp_value_in = 32'sh7FFFFFFF;
                     else if (acc_in < -AW'(64'sh80000000))
                        rsp_value_in = 32'sh80000000;
                     else
                        rsp_value_in = DW'(acc_in);
                  end
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   // divider starts the cycle after both operands are registered
   always_ff @(posedge clock) begin
      if (reset) div_go_ff <= 1'b0;
      else div_go_ff <= (state_ff == S_PV);
   end

   // key memory: writes only when idle, while the registered read runs in all states
   always_ff @(posedge clock) begin
      if (wr_en) key_mem[IW'(cnt_ff)] <= '{frame: req_frame, value: req_key_value,
                                            slope: req_key_slope};
      rd_ff <= key_mem[rd_addr];
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      last_ff       <= last_in;
      q_ff          <= q_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      nx_ff         <= nx_in;
      kn_ff         <= kn_in;
      kp_ff         <= kp_in;
      nf_ff         <= nf_in;
      d_ff          <= d_in;
      t_ff          <= t_in;
      t2_ff         <= t2_in;
      t3_ff         <= t3_in;
      h00_ff        <= h00_in;
      h01_ff        <= h01_in;
      h10_ff        <= h10_in;
      h11_ff        <= h11_in;
      step_ff       <= step_in;
      tmp_ff        <= tmp_in;
      acc_ff        <= acc_in;
      prod_ff       <= PW'(mul_a) * PW'(mul_b);
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_keys_held = hki_pkg::HELD_W'(cnt_ff);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for hermite_keyframe_interpolator_unit
// depends on hki_pkg and the unit; carries its own key table and hermite blend
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_op = hki_pkg::OP_QUERY;
   logic [hki_pkg::FRAME_W-1:0] req_frame = '0;
   logic signed [hki_pkg::DATA_W-1:0] req_key_value = '0;
   logic signed [hki_pkg::DATA_W-1:0] req_key_slope = '0;
   logic rsp_strobe;
   logic signed [hki_pkg::DATA_W-1:0] rsp_value;
   logic [1:0] rsp_status;
   logic [hki_pkg::HELD_W-1:0] rsp_keys_held;

   typedef struct packed {
      logic signed [hki_pkg::DATA_W-1:0] value;
      logic [1:0]                        status;
      logic [hki_pkg::HELD_W-1:0]        keys_held;
   } answer_type;

   // local copy of the key table
   hki_pkg::key_type table_keys[hki_pkg::MAX_KEYS];
   int unsigned loaded_keys;
   answer_type pending_answers[$];
   int error_count = 0;
   longint cycle_count = 0;

   hermite_keyframe_interpolator_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_frame(req_frame), .req_key_value(req_key_value),
      .req_key_slope(req_key_slope), .rsp_strobe(rsp_strobe), .rsp_value(rsp_value),
      .rsp_status(rsp_status), .rsp_keys_held(rsp_keys_held));

   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic longint floor_div_pow2(longint x, int n);
      return x >>> n;
   endfunction

   // cubic hermite blend between key a and key b
   function automatic logic signed [hki_pkg::DATA_W-1:0] hermite_blend(int unsigned q, int a,
                                                                       int b);
      longint fp, nf, d, t, t2, t3, h00, h01, h10, h11, sum;
      fp = table_keys[a].frame;
      nf = longint'(table_keys[b].frame) - fp;
      d = longint'(q) - fp;
      if (nf == 0) return table_keys[a].value;
      t = (d <<< 30) / nf;
      t2 = (t * t) >>> 30;
      t3 = (t2 * t) >>> 30;
      h00 = (longint'(1) <<< 30) - 3 * t2 + 2 * t3;
      h01 = 3 * t2 - 2 * t3;
      h10 = t - 2 * t2 + t3;
      h11 = t3 - t2;
      sum = floor_div_pow2(longint'(table_keys[a].value) * h00, 30);
      sum += floor_div_pow2(longint'(table_keys[b].value) * h01, 30);
      sum += floor_div_pow2(floor_div_pow2(longint'(table_keys[a].slope) * h10, 20) * nf, 14);
      sum += floor_div_pow2(floor_div_pow2(longint'(table_keys[b].slope) * h11, 20) * nf, 14);
      if (sum > 64'sd2147483647) return 32'sh7fffffff;
      if (sum < -64'sd2147483648) return 32'sh80000000;
      return sum[31:0];
   endfunction

   // lower-bound search and edge handling
   function automatic logic signed [hki_pkg::DATA_W-1:0] interpolate_at(int unsigned q);
      int unsigned lo, hi, mid, nx, pv;
      lo = 0;
      hi = loaded_keys;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (table_keys[mid].frame < q) lo = mid + 1;
         else hi = mid;
      end
      nx = (lo >= loaded_keys) ? loaded_keys - 1 : lo;
      pv = nx;
      if (q < table_keys[pv].frame && pv != 0) pv--;
      if (pv == nx) return table_keys[pv].value;
      return hermite_blend(q, pv, nx);
   endfunction

   // advance the local table by one beat and queue its answer
   function automatic void predict_beat(logic [1:0] op, logic [hki_pkg::FRAME_W-1:0] fr,
                                        logic signed [hki_pkg::DATA_W-1:0] kv,
                                        logic signed [hki_pkg::DATA_W-1:0] ks);
      answer_type a;
      a = '0;
      case (op)
         hki_pkg::OP_QUERY: begin
            if (loaded_keys == 0) a.status = hki_pkg::ST_EMPTY;
            else a.value = interpolate_at(fr);
         end
         hki_pkg::OP_LOAD: begin
            if (loaded_keys > 0 && fr <= table_keys[loaded_keys-1].frame)
               a.status = hki_pkg::ST_ORDER;
            else if (loaded_keys >= hki_pkg::MAX_KEYS) a.status = hki_pkg::ST_FULL;
            else begin
               table_keys[loaded_keys] = '{frame: fr, value: kv, slope: ks};
               loaded_keys++;
            end
         end
         hki_pkg::OP_CLEAR: loaded_keys = 0;
         default: ;
      endcase
      a.keys_held = loaded_keys[hki_pkg::HELD_W-1:0];
      pending_answers.push_back(a);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      answer_type w;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) report_mismatch("unexpected beat", 0, 0);
         else begin
            w = pending_answers.pop_front();
            if (rsp_value !== w.value) report_mismatch("value", rsp_value, w.value);
            if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
            if (rsp_keys_held !== w.keys_held)
               report_mismatch("keys_held", rsp_keys_held, w.keys_held);
         end
      end
   end

   // random gap, mostly short, sometimes long
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 80);
      repeat (n) @(negedge clock);
   endtask

   // send one beat: hold start until accepted
   task automatic send_beat(logic [1:0] op, logic [hki_pkg::FRAME_W-1:0] fr,
                            logic signed [hki_pkg::DATA_W-1:0] kv,
                            logic signed [hki_pkg::DATA_W-1:0] ks);
      req_op = op;
      req_frame = fr;
      req_key_value = kv;
      req_key_slope = ks;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_beat(op, fr, kv, ks);
      @(negedge clock);
      start = 1'b0;
      idle_gap();
   endtask

   task automatic drain();
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_beat(hki_pkg::OP_QUERY, 20'h12345, 0, 0);
      send_beat(hki_pkg::OP_LOAD, 20'h00000, 32'sh7fffffff, 32'sh7fffffff);
      send_beat(hki_pkg::OP_QUERY, 20'hfffff, 0, 0);
      send_beat(hki_pkg::OP_LOAD, 20'h00000, 1, 1);
      send_beat(hki_pkg::OP_LOAD, 20'h00010, 32'sh80000000, 32'sh80000000);
      send_beat(hki_pkg::OP_QUERY, 20'h00008, 0, 0);
      send_beat(hki_pkg::OP_QUERY, 20'h00010, 0, 0);
      send_beat(hki_pkg::OP_LOAD, 20'hfffff, 32'sh7fffffff, 32'sh80000000);
      send_beat(hki_pkg::OP_QUERY, 20'h80000, 0, 0);
      send_beat(hki_pkg::OP_QUERY, 20'hfffff, 0, 0);
      send_beat(hki_pkg::OP_LOAD, 20'h00020, 0, 0);
      send_beat(OP_UNUSED, 20'hfffff, -1, -1);
      send_beat(hki_pkg::OP_CLEAR, 0, 0, 0);
      send_beat(hki_pkg::OP_QUERY, 0, 0, 0);
      send_beat(hki_pkg::OP_LOAD, 20'h00100, -5 <<< 16, 3 <<< 16);
      send_beat(hki_pkg::OP_QUERY, 20'h00001, 0, 0);
      drain();
   endtask

   // fill past capacity, then an out-of-order load and a query
   task automatic test_full_table();
      send_beat(hki_pkg::OP_CLEAR, 0, 0, 0);
      for (int i = 0; i < hki_pkg::MAX_KEYS + 3; i++)
         send_beat(hki_pkg::OP_LOAD, 20'(i * 16 + 5), $urandom, $urandom);
      send_beat(hki_pkg::OP_LOAD, 20'h00000, 0, 0);
      send_beat(hki_pkg::OP_QUERY, 20'(hki_pkg::MAX_KEYS * 8), 0, 0);
      drain();
   endtask

   // well-formed key runs followed by queries, with some noise
   task automatic test_random_runs();
      int sent;
      int n;
      int unsigned f;
      logic [1:0] op;
      sent = 0;
      while (sent < 1800) begin
         send_beat(hki_pkg::OP_CLEAR, 0, 0, 0);
         sent++;
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, hki_pkg::MAX_KEYS + 2)
                                           : $urandom_range(1, 8);
         f = $urandom_range(0, 4000);
         for (int i = 0; i < n; i++) begin
            send_beat(hki_pkg::OP_LOAD, 20'(f), $urandom_range(0, 3) == 0 ? $urandom
                      : $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                      $urandom_range(0, 3) == 0 ? $urandom
                      : $signed($urandom_range(0, 1 << 20)) - (1 << 19));
            f = f + $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200000 : 300);
            if (f > 20'hfffff) f = 20'hfffff;
            sent++;
         end
         repeat ($urandom_range(3, 15)) begin
            op = ($urandom_range(0, 9) < 8) ? hki_pkg::OP_QUERY : 2'($urandom_range(1, 3));
            send_beat(op, ($urandom_range(0, 5) == 0) ? 20'($urandom)
                      : 20'($urandom_range(0, f + 20)), $urandom, $urandom);
            sent++;
         end
         if ($urandom_range(0, 19) == 0) drain();
      end
      drain();
   endtask

   initial begin
      loaded_keys = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_full_table();
      test_random_runs();
      repeat (100) @(negedge clock);
      if (error_count == 0 && pending_answers.size() == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
